>>> sv/paa_pkg.sv
// Package: shared types and constants for the process alarm annunciator.
`timescale 1ns / 1ps

package paa_pkg;

   // Field widths
   localparam int VALUE_WIDTH    = 24;
   localparam int COUNT_WIDTH    = 8;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Scans between blink phase toggles after reset
   localparam logic [COUNT_WIDTH-1:0] SCANS_PER_BLINK_RESET = 8'd6;

   // Register index, taken from the word address bit of paddr
   typedef enum logic {
      REG_SCANS_PER_BLINK = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_BELOW    = 2'd1,
      FAULT_NEGATIVE = 2'd2,
      FAULT_ABOVE    = 2'd3
   } fault_type;

   typedef enum logic [1:0] {
      LEVEL_NORMAL   = 2'd0,
      LEVEL_HIGH     = 2'd1,
      LEVEL_HIGHHIGH = 2'd2
   } level_type;

   // One measurement point as held in the input register
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic signed [VALUE_WIDTH-1:0] upper_limit;
      logic signed [VALUE_WIDTH-1:0] lower_limit;
      logic signed [VALUE_WIDTH-1:0] alarm_high;
      logic signed [VALUE_WIDTH-1:0] alarm_highhigh;
      logic                          point_active;
      logic                          source_active;
      logic                          last_of_scan;
   } point_type;

   // Per-point classification
   typedef struct packed {
      fault_type fault;
      level_type level;
   } grade_type;

   // Lamp and relay drive
   typedef struct packed {
      logic relay_yellow;
      logic relay_red;
      logic backlight;
      logic pickup;
   } lamp_type;

   // Annunciator status after one point
   typedef struct packed {
      lamp_type  lamps;
      level_type latched;
   } scan_stat_type;

endpackage

>>> sv/paa_grade.sv
// Point grader: sensor fault check and alarm level for one measurement point.
`timescale 1ns / 1ps

module paa_grade
   import paa_pkg::*;
(
   input  point_type point,
   output grade_type grade
);

   logic active;

   assign active = point.point_active & point.source_active;

   // Check faults in priority order, then grade a healthy point
   always_comb begin
      grade.fault = FAULT_NONE;
      grade.level = LEVEL_NORMAL;
      if (active) begin
         if (point.sample_value < point.lower_limit) begin
            grade.fault = FAULT_BELOW;
         end else if (point.sample_value[VALUE_WIDTH-1]) begin
            grade.fault = FAULT_NEGATIVE;
         end else if (point.sample_value > point.upper_limit) begin
            grade.fault = FAULT_ABOVE;
         end else if (point.sample_value > point.alarm_highhigh) begin
            grade.level = LEVEL_HIGHHIGH;
         end else if (point.sample_value > point.alarm_high) begin
            grade.level = LEVEL_HIGH;
         end
      end
   end

endmodule

>>> sv/paa_scan.sv
// Scan tracker: worst level of the scan, blink phase, latched level and lamp drive.
`timescale 1ns / 1ps

module paa_scan
   import paa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  level_type              point_level,
   input  logic                   last_of_scan,
   input  logic [COUNT_WIDTH-1:0] scans_per_blink,
   output scan_stat_type          stat_in,
   output level_type              latched_now
);

   level_type              scan_level_ff, scan_level_in;
   logic [COUNT_WIDTH-1:0] scan_counter_ff, scan_counter_in;
   logic                   blink_phase_ff, blink_phase_in;
   level_type              latched_ff, latched_in;
   lamp_type               lamps_ff, lamps_in;

   level_type              level_acc;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   toggle;

   // Fold this point into the scan level
   assign level_acc = (point_level > scan_level_ff) ? point_level : scan_level_ff;
   assign count_inc = scan_counter_ff + COUNT_WIDTH'(1);
   assign toggle    = last_of_scan && (count_inc >= scans_per_blink);

   // At scan end, advance counter and phase and clear the scan level; raise the latched level on a toggle to phase 1
   always_comb begin
      scan_counter_in = scan_counter_ff;
      blink_phase_in  = blink_phase_ff;
      scan_level_in   = level_acc;
      latched_in      = latched_ff;
      if (last_of_scan) begin
         scan_level_in   = LEVEL_NORMAL;
         scan_counter_in = toggle ? '0 : count_inc;
      end
      if (toggle) begin
         blink_phase_in = ~blink_phase_ff;
         if (!blink_phase_ff && (level_acc > latched_ff)) begin
            latched_in = level_acc;
         end
      end
   end

   // Drive lamps and relays on a phase toggle
   always_comb begin
      lamps_in = lamps_ff;
      if (toggle) begin
         if (blink_phase_in) begin
            unique case (latched_in)
               LEVEL_HIGHHIGH: begin
                  lamps_in.pickup       = 1'b1;
                  lamps_in.relay_red    = 1'b1;
                  lamps_in.relay_yellow = 1'b0;
               end
               LEVEL_HIGH: begin
                  lamps_in.pickup       = 1'b1;
                  lamps_in.backlight    = 1'b1;
                  lamps_in.relay_yellow = 1'b1;
                  lamps_in.relay_red    = 1'b0;
               end
               default: begin
                  lamps_in.backlight    = 1'b1;
                  lamps_in.relay_red    = 1'b0;
                  lamps_in.relay_yellow = 1'b0;
               end
            endcase
         end else begin
            lamps_in.pickup    = 1'b0;
            lamps_in.backlight = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_level_ff   <= LEVEL_NORMAL;
         scan_counter_ff <= '0;
         blink_phase_ff  <= 1'b0;
         latched_ff      <= LEVEL_NORMAL;
         lamps_ff        <= '0;
      end else if (step_en) begin
         scan_level_ff   <= scan_level_in;
         scan_counter_ff <= scan_counter_in;
         blink_phase_ff  <= blink_phase_in;
         latched_ff      <= latched_in;
         lamps_ff        <= lamps_in;
      end
   end

   assign stat_in.lamps   = lamps_in;
   assign stat_in.latched = latched_in;
   assign latched_now     = latched_ff;

endmodule

>>> sv/process_alarm_annunciator_unit.sv
// Throughput: one point per cycle; input register, grading and scan update,
// then the result register, which stalls only when rsp_ready is held low.
// Reset clears the scan level, scan counter, blink phase, latched level and all
// lamps and relays, and sets scans_per_blink to 6.
`timescale 1ns / 1ps

module process_alarm_annunciator_unit
   import paa_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   // Measurement point channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [VALUE_WIDTH-1:0]    req_sample_value,
   input  logic signed [VALUE_WIDTH-1:0]    req_upper_limit,
   input  logic signed [VALUE_WIDTH-1:0]    req_lower_limit,
   input  logic signed [VALUE_WIDTH-1:0]    req_alarm_high,
   input  logic signed [VALUE_WIDTH-1:0]    req_alarm_highhigh,
   input  logic                             req_point_active,
   input  logic                             req_source_active,
   input  logic                             req_last_of_scan,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_point_fault,
   output logic [1:0]                       rsp_point_level,
   output logic                             rsp_scan_done,
   output logic                             rsp_pickup_lamp,
   output logic                             rsp_backlight_lamp,
   output logic                             rsp_relay_red,
   output logic                             rsp_relay_yellow,
   output logic [1:0]                       rsp_latched_alarm,
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                             csr_pready
);

   logic                   in_valid_ff;
   point_type              in_point_ff;
   logic                   advance;

   logic                   rsp_valid_ff;
   grade_type              rsp_grade_ff;
   logic                   rsp_done_ff;
   scan_stat_type          rsp_stat_ff;

   grade_type              grade;
   scan_stat_type          stat_in;
   level_type              latched_now;

   logic [COUNT_WIDTH-1:0] spb_ff;
   reg_index_type          csr_index;
   logic                   csr_write;

   // Handshake: move the held point on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_point_ff.sample_value   <= req_sample_value;
         in_point_ff.upper_limit    <= req_upper_limit;
         in_point_ff.lower_limit    <= req_lower_limit;
         in_point_ff.alarm_high     <= req_alarm_high;
         in_point_ff.alarm_highhigh <= req_alarm_highhigh;
         in_point_ff.point_active   <= req_point_active;
         in_point_ff.source_active  <= req_source_active;
         in_point_ff.last_of_scan   <= req_last_of_scan;
      end
   end

   paa_grade u_grade (
      .point (in_point_ff),
      .grade (grade)
   );

   paa_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .point_level     (grade.level),
      .last_of_scan    (in_point_ff.last_of_scan),
      .scans_per_blink (spb_ff),
      .stat_in         (stat_in),
      .latched_now     (latched_now)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_grade_ff <= grade;
         rsp_done_ff  <= in_point_ff.last_of_scan;
         rsp_stat_ff  <= stat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_fault    = rsp_grade_ff.fault;
   assign rsp_point_level    = rsp_grade_ff.level;
   assign rsp_scan_done      = rsp_done_ff;
   assign rsp_pickup_lamp    = rsp_stat_ff.lamps.pickup;
   assign rsp_backlight_lamp = rsp_stat_ff.lamps.backlight;
   assign rsp_relay_red      = rsp_stat_ff.lamps.relay_red;
   assign rsp_relay_yellow   = rsp_stat_ff.lamps.relay_yellow;
   assign rsp_latched_alarm  = rsp_stat_ff.latched;

   // Register port: write on the access phase, read back combinationally
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= SCANS_PER_BLINK_RESET;
      end else if (csr_write && (csr_index == REG_SCANS_PER_BLINK)) begin
         spb_ff <= csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SCANS_PER_BLINK: csr_prdata = {{(CSR_DATA_WIDTH-COUNT_WIDTH){1'b0}}, spb_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // Latched level only rises
   assert property (@(posedge clock) disable iff (reset)
      advance |-> (stat_in.latched >= latched_now))
      else $error("latched level fell");

   // Relays are never both driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_relay_red && rsp_relay_yellow))
      else $error("both relays driven");

   // A graded level only comes with a healthy point
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_point_level != LEVEL_NORMAL)) |-> (rsp_point_fault == FAULT_NONE))
      else $error("alarm level on a faulted point");

   // Input stalls only when both registers hold a transaction
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled with room free");

endmodule

>>> test/tb_process_alarm_annunciator_unit.sv
// Testbench for the process alarm annunciator: directed and random points checked per result.
`timescale 1ns / 1ps

module tb_process_alarm_annunciator_unit
   import paa_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   typedef struct {
      point_type pt;
      bit        drain_first;
   } queued_point_type;

   typedef struct packed {
      fault_type fault;
      level_type level;
      logic      scan_done;
      lamp_type  lamps;
      level_type latched;
   } annunciation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_sample_value = '0;
   logic signed [VALUE_WIDTH-1:0] req_upper_limit = '0;
   logic signed [VALUE_WIDTH-1:0] req_lower_limit = '0;
   logic signed [VALUE_WIDTH-1:0] req_alarm_high = '0;
   logic signed [VALUE_WIDTH-1:0] req_alarm_highhigh = '0;
   logic                          req_point_active = 1'b0;
   logic                          req_source_active = 1'b0;
   logic                          req_last_of_scan = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_point_fault;
   logic [1:0] rsp_point_level;
   logic       rsp_scan_done;
   logic       rsp_pickup_lamp;
   logic       rsp_backlight_lamp;
   logic       rsp_relay_red;
   logic       rsp_relay_yellow;
   logic [1:0] rsp_latched_alarm;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   queued_point_type pending_points[$];
   annunciation_type expected_annunciations[$];
   point_type        offered_point;

   // Shadow of the annunciator state
   logic [COUNT_WIDTH-1:0] ann_scans_per_blink = SCANS_PER_BLINK_RESET;
   logic [COUNT_WIDTH-1:0] ann_scan_count = '0;
   level_type              ann_scan_level = LEVEL_NORMAL;
   level_type              ann_latched = LEVEL_NORMAL;
   logic                   ann_phase = 1'b0;
   lamp_type               ann_lamps = '0;

   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   bit steady_flow = 1'b0;

   process_alarm_annunciator_unit dut (.*);

   always #6 clock = ~clock;

   // Grade one point and advance the scan and blink state
   function automatic annunciation_type annunciate_point(input point_type p);
      annunciation_type       r;
      logic [COUNT_WIDTH-1:0] next_count;
      r = '0;
      r.fault = FAULT_NONE;
      r.level = LEVEL_NORMAL;
      if (p.point_active && p.source_active) begin
         if (p.sample_value < p.lower_limit) r.fault = FAULT_BELOW;
         else if (p.sample_value < 0) r.fault = FAULT_NEGATIVE;
         else if (p.sample_value > p.upper_limit) r.fault = FAULT_ABOVE;
         if (r.fault == FAULT_NONE) begin
            if (p.sample_value > p.alarm_highhigh) r.level = LEVEL_HIGHHIGH;
            else if (p.sample_value > p.alarm_high) r.level = LEVEL_HIGH;
         end
         if (r.level > ann_scan_level) ann_scan_level = r.level;
      end
      if (p.last_of_scan) begin
         next_count = ann_scan_count + 8'd1;
         if (next_count >= ann_scans_per_blink) begin
            ann_scan_count = '0;
            ann_phase = ~ann_phase;
            if (ann_phase && ann_scan_level > ann_latched) ann_latched = ann_scan_level;
            if (ann_phase) begin
               case (ann_latched)
                  LEVEL_HIGHHIGH: begin
                     ann_lamps.pickup = 1'b1;
                     ann_lamps.relay_red = 1'b1;
                     ann_lamps.relay_yellow = 1'b0;
                  end
                  LEVEL_HIGH: begin
                     ann_lamps.pickup = 1'b1;
                     ann_lamps.backlight = 1'b1;
                     ann_lamps.relay_yellow = 1'b1;
                     ann_lamps.relay_red = 1'b0;
                  end
                  default: begin
                     ann_lamps.backlight = 1'b1;
                     ann_lamps.relay_red = 1'b0;
                     ann_lamps.relay_yellow = 1'b0;
                  end
               endcase
            end else begin
               ann_lamps.pickup = 1'b0;
               ann_lamps.backlight = 1'b0;
            end
         end else begin
            ann_scan_count = next_count;
         end
         ann_scan_level = LEVEL_NORMAL;
      end
      r.scan_done = p.last_of_scan;
      r.lamps = ann_lamps;
      r.latched = ann_latched;
      return r;
   endfunction

   function automatic point_type make_point(input int v, input int up, input int lo,
                                            input int ah, input int ahh, input bit pa,
                                            input bit sa, input bit last);
      point_type p;
      p.sample_value = VALUE_WIDTH'(v);
      p.upper_limit = VALUE_WIDTH'(up);
      p.lower_limit = VALUE_WIDTH'(lo);
      p.alarm_high = VALUE_WIDTH'(ah);
      p.alarm_highhigh = VALUE_WIDTH'(ahh);
      p.point_active = pa;
      p.source_active = sa;
      p.last_of_scan = last;
      return p;
   endfunction

   // Well-formed point; cap bounds the grade that a fault-free value can reach
   function automatic point_type random_point(input int cap, input bit last);
      int lo, up, ah, ahh, base;
      up = $urandom_range(30000, 0);
      lo = int'($urandom_range(2000, 0)) - 1000;
      case (cap)
         0: begin
            ah = up + int'($urandom_range(500, 0));
            ahh = ah + int'($urandom_range(500, 0));
         end
         1: begin
            ah = $urandom_range(up, 0);
            ahh = up + int'($urandom_range(500, 0));
         end
         default: begin
            ah = $urandom_range(up, 0);
            ahh = $urandom_range(up, ah);
         end
      endcase
      case ($urandom_range(5, 0))
         0: base = lo;
         1: base = 0;
         2: base = up;
         3: base = ah;
         4: base = ahh;
         default: base = int'($urandom_range(33000, 0)) - 1500;
      endcase
      return make_point(base + int'($urandom_range(2, 0)) - 1, up, lo, ah, ahh,
                        $urandom_range(19, 0) != 0, $urandom_range(19, 0) != 0, last);
   endfunction

   function automatic point_type noise_point();
      return make_point($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom_range(1, 0) == 1, $urandom_range(1, 0) == 1,
                        $urandom_range(3, 0) == 0);
   endfunction

   task automatic queue_scans(input int n_items, input int cap, input int noise_pct,
                              input bit drain_mid);
      queued_point_type q;
      int               count, len;
      count = 0;
      while (count < n_items) begin
         len = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
         for (int k = 0; k < len; k++) begin
            q.pt = ($urandom_range(99, 0) < noise_pct) ? noise_point()
                                                      : random_point(cap, k == len - 1);
            q.drain_first = drain_mid && (count == n_items / 2);
            pending_points.push_back(q);
            count++;
         end
      end
   endtask

   task automatic push_directed(input point_type p);
      queued_point_type q;
      q.pt = p;
      q.drain_first = 1'b0;
      pending_points.push_back(q);
   endtask

   task automatic wait_idle();
      while (pending_points.size() != 0 || req_valid || expected_annunciations.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the blink divider, then read it back
   task automatic write_blink_divider(input logic [COUNT_WIDTH-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_SCANS_PER_BLINK, 2'b00};
      csr_pwdata <= {{(CSR_DATA_WIDTH - COUNT_WIDTH){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      ann_scans_per_blink = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[COUNT_WIDTH-1:0] !== value) begin
         mismatch_count++;
         $display("%0t ns: scans_per_blink readback expected %0d actual %0d",
                  $time, value, csr_prdata[COUNT_WIDTH-1:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Sender: offer queued points, hold each until its transaction completes
   always @(posedge clock) begin
      bit offer;
      queued_point_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_annunciations.push_back(annunciate_point(offered_point));
         if (!req_valid || req_ready) begin
            offer = pending_points.size() != 0 && (steady_flow || $urandom_range(99, 0) >= 9);
            if (offer && pending_points[0].drain_first && expected_annunciations.size() != 0)
               offer = 1'b0;
            if (offer) begin
               q = pending_points.pop_front();
               offered_point = q.pt;
               req_sample_value <= q.pt.sample_value;
               req_upper_limit <= q.pt.upper_limit;
               req_lower_limit <= q.pt.lower_limit;
               req_alarm_high <= q.pt.alarm_high;
               req_alarm_highhigh <= q.pt.alarm_highhigh;
               req_point_active <= q.pt.point_active;
               req_source_active <= q.pt.source_active;
               req_last_of_scan <= q.pt.last_of_scan;
            end
            req_valid <= offer;
         end
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // Receiver: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      annunciation_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_annunciations.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result, expected none actual fault %0d level %0d",
                        $time, rsp_point_fault, rsp_point_level);
            end else begin
               want = expected_annunciations.pop_front();
               check_field("point_fault", int'(want.fault), int'(rsp_point_fault));
               check_field("point_level", int'(want.level), int'(rsp_point_level));
               check_field("scan_done", int'(want.scan_done), int'(rsp_scan_done));
               check_field("pickup_lamp", int'(want.lamps.pickup), int'(rsp_pickup_lamp));
               check_field("backlight_lamp", int'(want.lamps.backlight),
                           int'(rsp_backlight_lamp));
               check_field("relay_red", int'(want.lamps.relay_red), int'(rsp_relay_red));
               check_field("relay_yellow", int'(want.lamps.relay_yellow),
                           int'(rsp_relay_yellow));
               check_field("latched_alarm", int'(want.latched), int'(rsp_latched_alarm));
            end
         end
         // Hold off for a long stretch when asked, else stall at random
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (holds_served < hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_flow || $urandom_range(99, 0) >= 9;
         end
      end
   end

   // Abort a run that stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      // Directed: fault order, grades, inactive points, field extremes
      push_directed(make_point(0, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(60, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(90, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(80, 100, -100, 50, 80, 1, 1, 1));
      push_directed(make_point(-200, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(-5, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(150, 100, -100, 50, 80, 1, 1, 0));
      push_directed(make_point(-5, 100, 0, 50, 80, 1, 1, 0));
      push_directed(make_point(200, 100, 300, 50, 80, 1, 1, 0));
      push_directed(make_point(-5, -20, -10, 50, 80, 1, 1, 0));
      push_directed(make_point(90, 100, -100, 50, 80, 0, 1, 0));
      push_directed(make_point(90, 100, -100, 50, 80, 1, 0, 1));
      push_directed(make_point(8388607, 8388607, -8388608, -8388608, 8388607, 1, 1, 0));
      push_directed(make_point(-8388608, 8388607, -8388608, 0, 0, 1, 1, 0));
      push_directed(make_point(8388607, 8388606, -8388608, 0, 0, 1, 1, 0));
      push_directed(make_point(-8388608, -8388608, -8388608, -8388608, -8388608, 1, 1, 0));
      push_directed(make_point(0, 0, 0, -1, -1, 1, 1, 1));
      push_directed(make_point(1, 10, 0, 0, 5, 1, 1, 1));
      push_directed(make_point(8388607, 8388607, 8388607, 8388607, 8388607, 0, 0, 1));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Green blinking on every scan, with no idling on either side
      write_blink_divider(8'd1);
      steady_flow = 1'b1;
      queue_scans(150, 0, 0, 1'b0);
      wait_idle();
      steady_flow = 1'b0;

      // Zero divider, then yellow, with a long receiver hold-off
      write_blink_divider(8'd0);
      queue_scans(100, 0, 0, 1'b0);
      queue_scans(150, 1, 0, 1'b0);
      hold_requests = hold_requests + 1;

      // Widest divider: the counter climbs without a toggle
      write_blink_divider(8'd255);
      queue_scans(150, 1, 0, 1'b0);

      // Lower the divider below the count; red arrives, sender drains midway
      write_blink_divider(8'd2);
      queue_scans(250, 2, 0, 1'b1);

      write_blink_divider(8'd3);
      queue_scans(250, 2, 20, 1'b0);

      write_blink_divider(8'($urandom_range(12, 1)));
      queue_scans(250, 2, 20, 1'b0);
      hold_requests = hold_requests + 1;

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
sv/paa_pkg.sv
sv/paa_grade.sv
sv/paa_scan.sv
sv/process_alarm_annunciator_unit.sv
test/tb_process_alarm_annunciator_unit.sv
